// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Property checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BFM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define BFM_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define BFM_ASSERT(lbl, clk, rst, prop)
`define BFM_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== src/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bloom filter membership package
// Shared constants, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bfm_pkg;

   localparam int SIZE_W = 17;
   localparam int HCNT_W = 2;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] MIX_MULT  = 32'h5bd1e995;
   localparam int          MIX_SHIFT = 15;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic REG_FILTER_SIZE = 1'b0;
   localparam logic REG_HASHES_USED = 1'b1;

   localparam logic [SIZE_W-1:0] FILTER_SIZE_RESET = 17'd65536;
   localparam logic [HCNT_W-1:0] HASHES_RESET      = 2'd2;
   localparam logic [HCNT_W-1:0] HASHES_MAX        = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] filter_size;
      logic [HCNT_W-1:0] hashes_used;
   } cfg_type;

   typedef struct packed {
      logic hash_en;
      logic clr_wr;
      logic div_load;
      logic div_step;
      logic mem_rd;
      logic mem_upd;
      logic rsp_load;
      logic sel;
   } cmd_type;

   typedef struct packed {
      logic              clr_last;
      logic              div_last;
      logic [HCNT_W-1:0] cfg_count;
      logic [HCNT_W-1:0] key_count;
   } status_type;

endpackage

// ===== src/bfm_channels.sv =====
// ----------------------------------------------------------------------------
// Bloom filter channels
// Valid/ready interfaces for the key byte and result channels.
// ----------------------------------------------------------------------------
interface bfm_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] key_byte;
   logic       byte_present;
   logic       last_byte;

   modport source (output valid, opcode, key_byte, byte_present, last_byte, input ready);
   modport sink (input valid, opcode, key_byte, byte_present, last_byte, output ready);
endinterface

interface bfm_rsp_if;
   logic valid;
   logic ready;
   logic done_opcode;
   logic maybe_present;

   modport source (output valid, done_opcode, maybe_present, input ready);
   modport sink (input valid, done_opcode, maybe_present, output ready);
endinterface

// ===== src/bfm_csr.sv =====
// ----------------------------------------------------------------------------
// Bloom filter register bank
// APB-style access to the filter size and hash count registers.
// ----------------------------------------------------------------------------
module bfm_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output bfm_pkg::cfg_type cfg
);

   logic [bfm_pkg::SIZE_W-1:0] size_ff;
   logic [bfm_pkg::HCNT_W-1:0] hcnt_ff;
   logic                       wr_en;
   logic                       reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= bfm_pkg::FILTER_SIZE_RESET;
         hcnt_ff <= bfm_pkg::HASHES_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            bfm_pkg::REG_FILTER_SIZE: size_ff <= pwdata[bfm_pkg::SIZE_W-1:0];
            bfm_pkg::REG_HASHES_USED: hcnt_ff <= pwdata[bfm_pkg::HCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         bfm_pkg::REG_FILTER_SIZE: prdata = {15'd0, size_ff};
         bfm_pkg::REG_HASHES_USED: prdata = {30'd0, hcnt_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   assign cfg.filter_size = size_ff;
   assign cfg.hashes_used = hcnt_ff;

endmodule

// ===== src/bfm_datapath.sv =====
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Running hashes, shared remainder unit, filter memory and result register.
// ----------------------------------------------------------------------------
module bfm_datapath #(
   parameter int FILTER_BITS = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  bfm_pkg::cmd_type    cmd,
   input  bfm_pkg::cfg_type    cfg,
   input  logic                opcode,
   input  logic [7:0]          key_byte,
   input  logic                byte_present,
   input  logic                last_byte,
   output bfm_pkg::status_type status,
   output logic                done_opcode,
   output logic                maybe_present
);

   localparam int WORD_COUNT = (FILTER_BITS + 63) / 64;
   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [31:0] FB32 = 32'(FILTER_BITS);
   localparam int SW = bfm_pkg::SIZE_W;

   logic [31:0]    fnv_ff, mix_ff, h0_ff, h1_ff;
   logic [31:0]    fnv_x, mix_x, mix_lo, fnv_nx, mix_nx, fnv_upd, mix_upd;
   logic [63:0]    fnv_prod, mix_prod;
   logic           op_ff, all_set_ff;
   logic [SW-1:0]  size_ff, eff_size;
   logic [1:0]     kcnt_ff, cfg_count;
   logic [31:0]    dvd_ff;
   logic [SW-1:0]  rem_ff;
   logic [SW:0]    rem_sh, rem_sub;
   logic [4:0]     step_ff;
   logic [31:0]    bit32;
   logic [AW-1:0]  word_addr, clr_ff;
   logic [63:0]    mask, rd_data_ff;
   logic [63:0]    mem [WORD_COUNT];
   logic           done_op_ff, maybe_ff;

   assign fnv_x    = fnv_ff ^ {24'd0, key_byte};
   assign mix_x    = mix_ff ^ {24'd0, key_byte};
   assign fnv_prod = {32'd0, fnv_x} * {32'd0, bfm_pkg::FNV_PRIME};
   assign mix_prod = {32'd0, mix_x} * {32'd0, bfm_pkg::MIX_MULT};
   assign fnv_nx   = fnv_prod[31:0];
   assign mix_lo   = mix_prod[31:0];
   assign mix_nx   = mix_lo ^ (mix_lo >> bfm_pkg::MIX_SHIFT);
   assign fnv_upd  = byte_present ? fnv_nx : fnv_ff;
   assign mix_upd  = byte_present ? mix_nx : mix_ff;

   always_comb begin
      priority if (cfg.filter_size == '0) begin
         eff_size = SW'(1);
      end else if ({15'd0, cfg.filter_size} > FB32) begin
         eff_size = FB32[SW-1:0];
      end else begin
         eff_size = cfg.filter_size;
      end
   end

   assign cfg_count = (cfg.hashes_used > bfm_pkg::HASHES_MAX) ?
                      bfm_pkg::HASHES_MAX : cfg.hashes_used;

   always_ff @(posedge clock) begin
      if (reset) begin
         fnv_ff <= bfm_pkg::FNV_BASIS;
         mix_ff <= 32'd0;
      end else if (cmd.hash_en) begin
         if (last_byte) begin
            fnv_ff <= bfm_pkg::FNV_BASIS;
            mix_ff <= 32'd0;
         end else begin
            fnv_ff <= fnv_upd;
            mix_ff <= mix_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kcnt_ff    <= '0;
         all_set_ff <= 1'b1;
      end else if (cmd.hash_en && last_byte) begin
         kcnt_ff    <= cfg_count;
         all_set_ff <= 1'b1;
      end else if (cmd.mem_upd && op_ff == bfm_pkg::OP_QUERY && !rd_data_ff[rem_ff[5:0]]) begin
         all_set_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_en && last_byte) begin
         h0_ff   <= fnv_upd;
         h1_ff   <= mix_upd;
         op_ff   <= opcode;
         size_ff <= eff_size;
      end
   end

   assign rem_sh  = {rem_ff, dvd_ff[31]};
   assign rem_sub = rem_sh - {1'b0, size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_load) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_ff <= cmd.sel ? h1_ff : h0_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         rem_ff <= (rem_sh >= {1'b0, size_ff}) ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
      end
   end

   assign bit32     = {15'd0, rem_ff};
   assign word_addr = bit32[AW+5:6];
   assign mask      = 64'd1 << rem_ff[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_ff] <= 64'd0;
      end else if (cmd.mem_upd && op_ff == bfm_pkg::OP_ADD) begin
         mem[word_addr] <= rd_data_ff | mask;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[word_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         done_op_ff <= op_ff;
         maybe_ff   <= (op_ff == bfm_pkg::OP_QUERY) & all_set_ff;
      end
   end

   assign done_opcode      = done_op_ff;
   assign maybe_present    = maybe_ff;
   assign status.clr_last  = (clr_ff == AW'(WORD_COUNT - 1));
   assign status.div_last  = (step_ff == 5'd31);
   assign status.cfg_count = cfg_count;
   assign status.key_count = kcnt_ff;

endmodule

// ===== src/bfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences the clearing pass, key-end bit selection and result transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bfm_pkg::status_type status,
   output bfm_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_RD    = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_UPD   = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.sel  = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.hash_en = 1'b1;
               idx_in      = 1'b0;
               if (req_last) begin
                  state_in = (status.cfg_count == 2'd0) ? ST_FIN : ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.mem_upd = 1'b1;
            if ({1'b0, idx_ff} + 2'd1 < status.key_count) begin
               idx_in   = 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `BFM_ASSERT(a_clear_once, clock, reset, (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
   `BFM_ASSERT(a_upd_after_wait, clock, reset, (state_ff == ST_UPD) |-> ($past(state_ff) == ST_WAIT))
   `BFM_ASSERT(a_load_in_range, clock, reset, (state_ff == ST_LOAD) |-> ({1'b0, idx_ff} < status.key_count))
   `BFM_NEVER(a_no_result_overrun, clock, reset, cmd.rsp_load && rsp_valid_ff && !rsp_ready)

endmodule

// ===== src/bloom_filter_membership.sv =====
// ----------------------------------------------------------------------------
// Bloom filter membership engine
// Two-hash Bloom filter that adds keys and answers membership queries.
// ----------------------------------------------------------------------------
// Keys enter on req_ch one byte per transfer; the transfer that carries
// last_byte closes the key, and its opcode selects add or query. A transfer
// with byte_present low adds no byte, so it can close an empty key. Each
// closed key yields one transfer on rsp_ch: the opcode and, for a query,
// whether every selected filter bit was set.
// Bytes inside a key are taken one per cycle. A closing transfer holds the
// input off while each hash in use runs through a shared 32-step remainder
// unit, then a read of the filter memory that an add writes back with the
// selected bit set. The result register is loaded at the end and appears
// on the following cycle. After reset the filter memory is swept to zero,
// one 64-bit word a cycle over all its words (1024 by default), with the
// input held off. A stalled result holds the engine in its final step
// while rsp_ch.ready is low; the next key's bytes are taken once the result
// register is loaded. The user must write registers over the APB-style port
// only while the engine is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bloom_filter_membership #(
   parameter int FILTER_BITS = 65536
) (
   input  logic              clock,
   input  logic              reset,
   bfm_req_if.sink           req_ch,
   bfm_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   bfm_pkg::cfg_type    cfg;
   bfm_pkg::cmd_type    cmd;
   bfm_pkg::status_type status;

   bfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_byte),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bfm_datapath #(
      .FILTER_BITS (FILTER_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .opcode        (req_ch.opcode),
      .key_byte      (req_ch.key_byte),
      .byte_present  (req_ch.byte_present),
      .last_byte     (req_ch.last_byte),
      .status        (status),
      .done_opcode   (rsp_ch.done_opcode),
      .maybe_present (rsp_ch.maybe_present)
   );

endmodule

// ===== bench/bloom_filter_membership_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter membership testbench
// Sends keys byte by byte, mixed with empty items, as adds and queries, under
// a series of filter sizes and hash counts. The filter bits and running
// hashes are tracked alongside the engine, and every result transfer is
// compared with the answer due for the oldest closed key.
// ----------------------------------------------------------------------------
module bloom_filter_membership_tb;

   localparam int FILTER_BITS  = 65536;
   localparam int ITEM_TARGET  = 1700;
   localparam int PHASES       = 12;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [2:0] ADDR_FILTER_SIZE = {bfm_pkg::REG_FILTER_SIZE, 2'b00};
   localparam logic [2:0] ADDR_HASHES_USED = {bfm_pkg::REG_HASHES_USED, 2'b00};

   typedef struct packed {
      logic done_opcode;
      logic maybe_present;
   } answer_type;

   class membership_scoreboard;
      logic [bfm_pkg::SIZE_W-1:0] size_reg;
      logic [bfm_pkg::HCNT_W-1:0] count_reg;
      logic [31:0]                fnv_hash;
      logic [31:0]                mix_hash;
      bit                         filter_bits [FILTER_BITS];
      answer_type                 pending_answers [$];
      int                         errors;

      function new();
         size_reg  = bfm_pkg::FILTER_SIZE_RESET;
         count_reg = bfm_pkg::HASHES_RESET;
         fnv_hash  = bfm_pkg::FNV_BASIS;
         mix_hash  = '0;
         errors    = 0;
         foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      endfunction

      function void write_reg(logic [2:0] addr, logic [31:0] value);
         if (addr == ADDR_FILTER_SIZE) begin
            size_reg = value[bfm_pkg::SIZE_W-1:0];
         end else if (addr == ADDR_HASHES_USED) begin
            count_reg = value[bfm_pkg::HCNT_W-1:0];
         end
      endfunction

      function void note_key_transfer(logic op, logic [7:0] kb, logic present,
                                      logic last);
         logic [31:0] hv [2];
         logic [31:0] modulus;
         logic [31:0] sel_bit;
         int          count;
         logic        all_set;
         answer_type  answer;
         if (present) begin
            fnv_hash = (fnv_hash ^ {24'd0, kb}) * bfm_pkg::FNV_PRIME;
            mix_hash = (mix_hash ^ {24'd0, kb}) * bfm_pkg::MIX_MULT;
            mix_hash = mix_hash ^ (mix_hash >> bfm_pkg::MIX_SHIFT);
         end
         if (last) begin
            hv[0] = fnv_hash;
            hv[1] = mix_hash;
            count = (count_reg > bfm_pkg::HASHES_MAX) ? int'(bfm_pkg::HASHES_MAX)
                                                      : int'(count_reg);
            if (size_reg == '0) begin
               modulus = 32'd1;
            end else if (size_reg > FILTER_BITS) begin
               modulus = 32'(FILTER_BITS);
            end else begin
               modulus = {15'd0, size_reg};
            end
            all_set = 1'b1;
            for (int i = 0; i < count; i++) begin
               sel_bit = hv[i] % modulus;
               if (op == bfm_pkg::OP_ADD) begin
                  filter_bits[sel_bit] = 1'b1;
               end else if (!filter_bits[sel_bit]) begin
                  all_set = 1'b0;
               end
            end
            fnv_hash = bfm_pkg::FNV_BASIS;
            mix_hash = '0;
            answer.done_opcode   = op;
            answer.maybe_present = (op == bfm_pkg::OP_QUERY) && all_set;
            pending_answers.push_back(answer);
         end
      endfunction

      function void check_membership_result(logic op, logic maybe);
         answer_type due;
         if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, done_opcode %b maybe_present %b",
                     $time, op, maybe);
         end else begin
            due = pending_answers.pop_front();
            if (op !== due.done_opcode) begin
               errors++;
               $display("%0t: done_opcode expected %b actual %b",
                        $time, due.done_opcode, op);
            end
            if (maybe !== due.maybe_present) begin
               errors++;
               $display("%0t: maybe_present expected %b actual %b",
                        $time, due.maybe_present, maybe);
            end
         end
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bfm_req_if req_ch ();
   bfm_rsp_if rsp_ch ();

   membership_scoreboard sb = new();

   int          cycle_count = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   int          recv_mode = 0;
   logic [7:0]  cur_key [$];
   logic [7:0]  key_pool [$];
   int          key_start [$];
   int          key_len [$];

   bloom_filter_membership #(
      .FILTER_BITS(FILTER_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bloom_filter_membership: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_key_transfer(req_ch.opcode, req_ch.key_byte, req_ch.byte_present,
                                 req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_membership_result(rsp_ch.done_opcode, rsp_ch.maybe_present);
      end
   end

   always @(posedge clock) begin
      if (cycle_count % 256 == 0)
         recv_mode <= $urandom_range(0, 2);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (recv_mode)
            0: begin
               rsp_ch.ready <= 1'b1;
            end
            1: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left <= $urandom_range(1, 30);
            end
         endcase
      end
   end

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic push_item(input logic op, input logic [7:0] kb, input logic present,
                            input logic last);
      pace();
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.key_byte     <= kb;
      req_ch.byte_present <= present;
      req_ch.last_byte    <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (present || last)
         items_sent++;
   endtask

   task automatic send_key(input logic op, input bit empty_close);
      int n;
      logic is_last;
      n = cur_key.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0)
            push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
         is_last = (i == n - 1) && !empty_close;
         push_item(is_last ? op : logic'($urandom_range(0, 1)), cur_key[i], 1'b1, is_last);
      end
      if (n == 0 || empty_close)
         push_item(op, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic make_key();
      int n;
      int pick;
      cur_key.delete();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 15);
         cur_key.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic store_key();
      key_start.push_back(key_pool.size());
      key_len.push_back(cur_key.size());
      foreach (cur_key[i]) key_pool.push_back(cur_key[i]);
   endtask

   task automatic recall_key();
      int idx;
      idx = $urandom_range(0, key_len.size() - 1);
      cur_key.delete();
      for (int i = 0; i < key_len[idx]; i++)
         cur_key.push_back(key_pool[key_start[idx] + i]);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(addr, value);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   int          phase_sizes [PHASES] = '{64, 1, 0, 131071, 65537, 100, 4096, 65535, 200,
                                         2, 65536, 1000};
   int          phase_counts [PHASES] = '{2, 1, 3, 2, 0, 2, 1, 3, 2, 1, 2, 2};
   int          phase_end;
   int          choice;
   logic [31:0] upper;

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = bfm_pkg::OP_ADD;
      req_ch.key_byte = 8'h00;
      req_ch.byte_present = 1'b0;
      req_ch.last_byte    = 1'b0;
      rsp_ch.ready    = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty keys on a clear filter, then keys of extreme bytes.
      cur_key.delete();
      send_key(bfm_pkg::OP_QUERY, 1'b1);
      send_key(bfm_pkg::OP_ADD, 1'b1);
      send_key(bfm_pkg::OP_QUERY, 1'b1);
      cur_key = '{8'h00};
      send_key(bfm_pkg::OP_QUERY, 1'b0);
      push_item(bfm_pkg::OP_QUERY, 8'hA5, 1'b0, 1'b0);
      cur_key = '{8'h00, 8'hFF};
      send_key(bfm_pkg::OP_ADD, 1'b0);
      send_key(bfm_pkg::OP_QUERY, 1'b0);
      cur_key = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_key(bfm_pkg::OP_ADD, 1'b1);
      send_key(bfm_pkg::OP_QUERY, 1'b0);
      cur_key = '{8'h80, 8'h01};
      send_key(bfm_pkg::OP_QUERY, 1'b0);
      settle();
      csr_write(ADDR_HASHES_USED, 32'd0);
      cur_key = '{8'h12, 8'h34};
      send_key(bfm_pkg::OP_QUERY, 1'b0);
      send_key(bfm_pkg::OP_ADD, 1'b0);
      cur_key = '{8'h7E};
      send_key(bfm_pkg::OP_QUERY, 1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         upper = $urandom_range(0, 3) == 0 ? $urandom : 32'd0;
         csr_write(ADDR_FILTER_SIZE, {upper[31:bfm_pkg::SIZE_W], 17'(phase_sizes[p])});
         upper = $urandom_range(0, 3) == 0 ? $urandom : 32'd0;
         csr_write(ADDR_HASHES_USED, {upper[31:bfm_pkg::HCNT_W], 2'(phase_counts[p])});
         phase_end = items_sent + (ITEM_TARGET - 25) / PHASES;
         while (items_sent < phase_end) begin
            choice = $urandom_range(0, 9);
            if (choice <= 3) begin
               make_key();
               store_key();
               send_key(bfm_pkg::OP_ADD, $urandom_range(0, 5) == 0);
            end else if (choice <= 6 && key_len.size() > 0) begin
               recall_key();
               send_key(bfm_pkg::OP_QUERY, $urandom_range(0, 5) == 0);
            end else if (choice <= 8) begin
               make_key();
               send_key(bfm_pkg::OP_QUERY, $urandom_range(0, 5) == 0);
            end else begin
               cur_key.delete();
               send_key(1'($urandom_range(0, 1)), 1'b1);
            end
         end
         settle();
      end

      if (sb.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("bloom_filter_membership: match");
      end else begin
         $display("bloom_filter_membership: mismatch");
      end
      $finish;
   end

endmodule
